>>> hw/rtl/rss_pkg.sv
// Package for the record selection sort block: sizes, record type and sequencer states.
// No dependencies; every other file of the block except rss_ram uses it.
package rss_pkg;

	localparam int unsigned MAX_RECORDS = 64;
	localparam int unsigned TAG_BITS    = 16;

	localparam int unsigned KEY_W     = 32;
	localparam int unsigned OUT_TAG_W = 16;
	localparam int unsigned TAG_W     = (TAG_BITS < OUT_TAG_W) ? TAG_BITS : OUT_TAG_W;
	localparam int unsigned IDX_W     = $clog2(MAX_RECORDS);
	localparam int unsigned CNT_W     = $clog2(MAX_RECORDS + 1);

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} rec_t;

	localparam int unsigned REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

>>> hw/rtl/rss_if.sv
// Valid/ready channel interfaces for incoming records and sorted results.
// Depends on rss_pkg for field widths.
interface rss_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [rss_pkg::KEY_W-1:0] salary_key;
	logic [rss_pkg::OUT_TAG_W-1:0]    record_tag;
	logic                            last_record;

	modport source (output valid, output salary_key, output record_tag, output last_record,
		input ready);
	modport sink (input valid, input salary_key, input record_tag, input last_record,
		output ready);
endinterface

interface rss_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [rss_pkg::KEY_W-1:0] sorted_key;
	logic [rss_pkg::OUT_TAG_W-1:0]    sorted_tag;
	logic                            end_of_run;
	logic                            overflowed;

	modport source (output valid, output sorted_key, output sorted_tag, output end_of_run,
		output overflowed, input ready);
	modport sink (input valid, input sorted_key, input sorted_tag, input end_of_run,
		input overflowed, output ready);
endinterface

>>> hw/rtl/record_selection_sort_desc_unit.sv
// Top level of the descending record sorter: record RAM plus load/sort/emit sequencer.
// Depends on rss_pkg, rss_if, rss_ram and rss_seq.
//
// Usage: records enter on in_rec (valid/ready) as a signed salary_key with a record_tag.
// Each accepted transaction is stored while in_rec.ready is high. The
// transaction with last_record set closes the set; in_rec.ready then drops while the
// set of N held records is sorted into descending key order and emitted on out_rec.
// Up to 64 records are held; records beyond that are dropped and every result of the
// set shows overflowed. end_of_run marks the final result of the set.
// Throughput: loading is one record per cycle. The sort makes N-1 passes over the
// single read port of the record RAM; each pass scans the unsorted part, drains the
// read latency, then makes two swap writes. Emission reads each result from the RAM
// and loads it into the output register.
// A stalled receiver holds the result in the output register and the sequencer waits;
// nothing is lost. in_rec.ready returns right after the last result is loaded.
// Reset: asynchronous, active low; clears the record count, overflow flag and
// sequencer. The RAM is not cleared; only entries written in the current set are read.
module record_selection_sort_desc_unit (
	input  logic      clk,
	input  logic      arst_n,
	rss_in_if.sink    in_rec,
	rss_out_if.source out_rec
);
	import rss_pkg::*;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	rec_t             ram_wdata, ram_rdata;

	rss_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_rec    (in_rec),
		.out_rec   (out_rec),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	rss_ram #(
		.DEPTH (MAX_RECORDS),
		.WIDTH (REC_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> hw/rtl/rss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rss_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 8,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/rss_seq.sv
// Load, selection-sort and emit sequencer with the compare stage and output register.
// Depends on rss_pkg and rss_if; drives the record RAM ports.
module rss_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	rss_in_if.sink                    in_rec,
	rss_out_if.source                 out_rec,
	output logic                      ram_we,
	output logic [rss_pkg::IDX_W-1:0] ram_waddr,
	output rss_pkg::rec_t             ram_wdata,
	output logic                      ram_re,
	output logic [rss_pkg::IDX_W-1:0] ram_raddr,
	input  rss_pkg::rec_t             ram_rdata
);
	import rss_pkg::*;

	state_t                  state_q, state_nx;
	logic [CNT_W-1:0]        count_q, n_q, pos_q, scan_q, emit_q;
	logic                    ovf_q, set_ovf_q;
	logic [IDX_W-1:0]        best_idx_q;
	rec_t                    best_rec_q, pos_rec_q;
	logic                    rd_vld_s1, rd_first_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    out_valid_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [OUT_TAG_W-1:0]    out_tag_q;
	logic                    out_end_q, out_ovf_q;
	logic                    in_acc, room, out_take, emit_last, more_pos;
	logic [CNT_W-1:0]        count_nx;
	rec_t                    in_data;

	assign in_acc    = in_rec.valid && in_rec.ready;
	assign room      = (count_q != CNT_W'(MAX_RECORDS));
	assign count_nx  = count_q + CNT_W'(room);
	assign out_take  = out_valid_q && out_rec.ready;
	assign emit_last = (emit_q == n_q - CNT_W'(1));
	assign more_pos  = ((CNT_W + 1)'(pos_q) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(n_q);
	assign in_data.key = in_rec.salary_key;
	assign in_data.tag = in_rec.record_tag[TAG_W-1:0];

	assign out_rec.valid      = out_valid_q;
	assign out_rec.sorted_key = out_key_q;
	assign out_rec.sorted_tag = out_tag_q;
	assign out_rec.end_of_run = out_end_q;
	assign out_rec.overflowed = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		in_rec.ready = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = count_q[IDX_W-1:0];
		ram_wdata    = in_data;
		ram_re       = 1'b0;
		ram_raddr    = scan_q[IDX_W-1:0];
		case (state_q)
			ST_LOAD: begin
				in_rec.ready = 1'b1;
				ram_we       = in_acc && room;
				if (in_acc && in_rec.last_record) begin
					state_nx = (count_nx == CNT_W'(1)) ? ST_EMIT_RD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_re = 1'b1;
				if (scan_q == n_q - CNT_W'(1)) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nx = ST_SWAP_A;
			end
			ST_SWAP_A: begin
				ram_we    = 1'b1;
				ram_waddr = best_idx_q;
				ram_wdata = pos_rec_q;
				state_nx  = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IDX_W-1:0];
				ram_wdata = best_rec_q;
				state_nx  = more_pos ? ST_SCAN : ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				ram_raddr = emit_q[IDX_W-1:0];
				if (!out_valid_q || out_rec.ready) begin
					ram_re   = 1'b1;
					state_nx = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				state_nx = emit_last ? ST_LOAD : ST_EMIT_RD;
			end
			default: begin
				state_nx = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			set_ovf_q   <= 1'b0;
			n_q         <= '0;
			pos_q       <= '0;
			scan_q      <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_LOAD && in_acc) begin
				if (in_rec.last_record) begin
					n_q       <= count_nx;
					set_ovf_q <= ovf_q | !room;
					count_q   <= '0;
					ovf_q     <= 1'b0;
					pos_q     <= '0;
					scan_q    <= '0;
					emit_q    <= '0;
				end else begin
					count_q <= count_nx;
					ovf_q   <= ovf_q | !room;
				end
			end
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (state_q == ST_SWAP_B) begin
				pos_q  <= pos_q + CNT_W'(1);
				scan_q <= pos_q + CNT_W'(1);
			end
			if (state_q == ST_EMIT_LD) begin
				emit_q      <= emit_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1   <= scan_q[IDX_W-1:0];
		rd_first_s1 <= (scan_q == pos_q);
		if (rd_vld_s1) begin
			if (rd_first_s1 || ($signed(ram_rdata.key) > $signed(best_rec_q.key))) begin
				best_rec_q <= ram_rdata;
				best_idx_q <= rd_idx_s1;
			end
			if (rd_first_s1) begin
				pos_rec_q <= ram_rdata;
			end
		end
		if (state_q == ST_EMIT_LD) begin
			out_key_q <= ram_rdata.key;
			out_tag_q <= OUT_TAG_W'(ram_rdata.tag);
			out_end_q <= emit_last;
			out_ovf_q <= set_ovf_q;
		end
	end

endmodule

>>> hw/rtl/rss_checker.sv
// Port-level assertions for record_selection_sort_desc_unit and the bind that attaches them.
// Depends on rss_pkg for widths.
module rss_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            in_last,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [rss_pkg::KEY_W-1:0] out_key,
	input logic [rss_pkg::OUT_TAG_W-1:0]    out_tag,
	input logic                            out_end,
	input logic                            out_ovf
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
			&& $stable(out_end) && $stable(out_ovf))
		else $error("result changed while stalled");

	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input still open after last record");

	a_emit_blocks_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_end |=> !in_ready)
		else $error("input open in the middle of a run");

	a_ovf_per_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_end |=> !out_valid || (out_ovf == $past(out_ovf)))
		else $error("overflow flag changed within a run");

endmodule

bind record_selection_sort_desc_unit rss_checker u_rss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_rec.valid),
	.in_ready  (in_rec.ready),
	.in_last   (in_rec.last_record),
	.out_valid (out_rec.valid),
	.out_ready (out_rec.ready),
	.out_key   (out_rec.sorted_key),
	.out_tag   (out_rec.sorted_tag),
	.out_end   (out_rec.end_of_run),
	.out_ovf   (out_rec.overflowed)
);
